[rtl/core/fca_pkg.sv]
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types and constants for the block allocation table: sizes, entry
// encodings, command and status codes, and controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package fca_pkg;

   localparam int NUM_BLOCKS      = 2048;
   localparam int RESERVED_BLOCKS = 2;

   localparam int IDX_W   = 11;                        // block_index / result_block
   localparam int CNT_W   = 12;                        // block_count / blocks_changed
   localparam int ENTRY_W = 16;
   localparam int ADDR_W  = $clog2(NUM_BLOCKS);
   localparam int PTR_W   = $clog2(NUM_BLOCKS + 1);    // holds NUM_BLOCKS itself

   localparam logic [ENTRY_W-1:0] ENTRY_FREE = 16'hFFFE;
   localparam logic [ENTRY_W-1:0] ENTRY_END  = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_FORMAT = 2'd0,
      CMD_ALLOC  = 2'd1,
      CMD_FREE   = 2'd2,
      CMD_PEEK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_CAPTURE,
      OP_REJECT,
      OP_CLEAR,
      OP_SCAN,
      OP_SEAL,
      OP_WALK_RD,
      OP_WALK_CHK,
      OP_PEEK_RD,
      OP_PEEK_CHK
   } op_type;

   typedef struct packed {
      op_type op;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    bad;         // zero count or out-of-range index
      logic    clr_last;
      logic    scan_done;
      logic    scan_full;
      logic    walk_stop;
   } stat_type;

endpackage : fca_pkg

`default_nettype wire

[rtl/core/fca_datapath.sv]
// ----------------------------------------------------------------------------
// fca_datapath
// Table memory, scan / walk pointers, request capture and result registers.
// Executes one operation per cycle as selected by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module fca_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire fca_pkg::ctl_type           ctl,
   output fca_pkg::stat_type               stat,
   input  wire logic [1:0]                 req_cmd,
   input  wire logic [fca_pkg::IDX_W-1:0]  req_block_index,
   input  wire logic [fca_pkg::CNT_W-1:0]  req_block_count,
   output logic [1:0]                      rsp_status,
   output logic [fca_pkg::IDX_W-1:0]       rsp_result_block,
   output logic                            rsp_chain_end,
   output logic                            rsp_entry_free,
   output logic [fca_pkg::CNT_W-1:0]       rsp_blocks_changed
);
   import fca_pkg::*;

   logic [ENTRY_W-1:0] mem [NUM_BLOCKS];
   logic [ENTRY_W-1:0] rdata_ff;
   logic [ADDR_W-1:0]  raddr;
   logic               we;
   logic [ADDR_W-1:0]  waddr;
   logic [ENTRY_W-1:0] wdata;

   cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [ADDR_W-1:0]  blk_ff, blk_in;
   logic [ADDR_W-1:0]  prev_ff, prev_in;
   logic [ADDR_W-1:0]  chk_ff, chk_in;
   logic               have_prev_ff, have_prev_in;
   logic               pend_ff, pend_in;
   logic [CNT_W-1:0]   changed_ff, changed_in;
   status_type         status_ff, status_in;
   logic [IDX_W-1:0]   result_ff, result_in;
   logic               cend_ff, cend_in;
   logic               efree_ff, efree_in;

   logic               idx_bad;
   logic               ptr_in_range;
   logic               hit;
   logic [CNT_W-1:0]   changed_inc;

   assign idx_bad      = {1'b0, idx_ff} >= (IDX_W+1)'(NUM_BLOCKS);
   assign ptr_in_range = ptr_ff < PTR_W'(NUM_BLOCKS);
   assign hit          = pend_ff && (rdata_ff == ENTRY_FREE);
   assign changed_inc  = changed_ff + 1'b1;

   always_comb begin
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      blk_in       = blk_ff;
      prev_in      = prev_ff;
      chk_in       = chk_ff;
      have_prev_in = have_prev_ff;
      pend_in      = pend_ff;
      changed_in   = changed_ff;
      status_in    = status_ff;
      result_in    = result_ff;
      cend_in      = cend_ff;
      efree_in     = efree_ff;
      raddr        = '0;
      we           = 1'b0;
      waddr        = '0;
      wdata        = ENTRY_FREE;
      stat.cmd       = cmd_ff;
      stat.clr_last  = 1'b0;
      stat.scan_done = 1'b0;
      stat.scan_full = 1'b0;
      stat.walk_stop = 1'b0;

      unique case (cmd_ff)
         CMD_ALLOC:           stat.bad = cnt_ff == '0;
         CMD_FREE, CMD_PEEK:  stat.bad = idx_bad;
         default:             stat.bad = 1'b0;
      endcase

      unique case (ctl.op)
         OP_IDLE: begin
         end
         OP_CAPTURE: begin
            cmd_in       = cmd_type'(req_cmd);
            idx_in       = req_block_index;
            cnt_in       = req_block_count;
            ptr_in       = '0;
            blk_in       = ADDR_W'(req_block_index);
            have_prev_in = 1'b0;
            pend_in      = 1'b0;
            changed_in   = '0;
            status_in    = ST_OK;
            result_in    = '0;
            cend_in      = 1'b0;
            efree_in     = 1'b0;
         end
         OP_REJECT: begin
            status_in = ST_BAD;
         end
         OP_CLEAR: begin
            we            = 1'b1;
            waddr         = ptr_ff[ADDR_W-1:0];
            wdata         = (ptr_ff < PTR_W'(RESERVED_BLOCKS)) ? ENTRY_END : ENTRY_FREE;
            stat.clr_last = ptr_ff == PTR_W'(NUM_BLOCKS - 1);
            ptr_in        = stat.clr_last ? '0 : ptr_ff + 1'b1;
         end
         OP_SCAN: begin
            // streaming scan: read issued at ptr, data checked in the following cycle
            if (hit) begin
               if (have_prev_ff) begin
                  we    = 1'b1;
                  waddr = prev_ff;
                  wdata = ENTRY_W'(chk_ff);
               end else begin
                  result_in = IDX_W'(chk_ff);
               end
               prev_in        = chk_ff;
               have_prev_in   = 1'b1;
               changed_in     = changed_inc;
               stat.scan_done = changed_inc == cnt_ff;
            end
            raddr   = ptr_ff[ADDR_W-1:0];
            pend_in = ptr_in_range;
            chk_in  = ptr_ff[ADDR_W-1:0];
            if (ptr_in_range) begin
               ptr_in = ptr_ff + 1'b1;
            end
            stat.scan_full = !pend_ff && !ptr_in_range;
            if (stat.scan_full) begin
               status_in = ST_FULL;
               result_in = '0;
            end
         end
         OP_SEAL: begin
            we    = have_prev_ff;
            waddr = prev_ff;
            wdata = ENTRY_END;
         end
         OP_WALK_RD: begin
            raddr = blk_ff;
         end
         OP_WALK_CHK: begin
            if (rdata_ff == ENTRY_FREE) begin
               if (changed_ff == '0) begin
                  status_in = ST_BAD;
               end
               stat.walk_stop = 1'b1;
            end else begin
               we             = 1'b1;
               waddr          = blk_ff;
               wdata          = ENTRY_FREE;
               changed_in     = changed_inc;
               stat.walk_stop = (rdata_ff == ENTRY_END)
                             || (rdata_ff >= ENTRY_W'(NUM_BLOCKS))
                             || (changed_inc == CNT_W'(NUM_BLOCKS));
               blk_in         = rdata_ff[ADDR_W-1:0];
            end
         end
         OP_PEEK_RD: begin
            raddr = ADDR_W'(idx_ff);
         end
         OP_PEEK_CHK: begin
            efree_in = rdata_ff == ENTRY_FREE;
            cend_in  = rdata_ff == ENTRY_END;
            if (rdata_ff != ENTRY_FREE && rdata_ff != ENTRY_END) begin
               result_in = IDX_W'(rdata_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      blk_ff       <= blk_in;
      prev_ff      <= prev_in;
      chk_ff       <= chk_in;
      have_prev_ff <= have_prev_in;
      pend_ff      <= pend_in;
      changed_ff   <= changed_in;
      status_ff    <= status_in;
      result_ff    <= result_in;
      cend_ff      <= cend_in;
      efree_ff     <= efree_in;
   end

   assign rsp_status         = status_ff;
   assign rsp_result_block   = result_ff;
   assign rsp_chain_end      = cend_ff;
   assign rsp_entry_free     = efree_ff;
   assign rsp_blocks_changed = changed_ff;

endmodule : fca_datapath

`default_nettype wire

[rtl/core/fca_ctrl.sv]
// ----------------------------------------------------------------------------
// fca_ctrl
// Command sequencer: decodes a request, steps the datapath through the
// clear sweep, free-block scan, chain walk or entry read, and strobes the response.
// ----------------------------------------------------------------------------
`default_nettype none

module fca_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output logic                   rsp_valid,
   output fca_pkg::ctl_type       ctl,
   input  wire fca_pkg::stat_type stat
);
   import fca_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_DECIDE   = 10'b00_0000_0010,
      S_CLEAR    = 10'b00_0000_0100,
      S_SCAN     = 10'b00_0000_1000,
      S_SEAL     = 10'b00_0001_0000,
      S_WALK_RD  = 10'b00_0010_0000,
      S_WALK_CHK = 10'b00_0100_0000,
      S_PEEK_RD  = 10'b00_1000_0000,
      S_PEEK_CHK = 10'b01_0000_0000,
      S_DONE     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      fmt_ff, fmt_in;     // clear sweep belongs to a format request

   always_comb begin
      state_in = state_ff;
      fmt_in   = fmt_ff;
      ctl.op   = OP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.op   = OP_CAPTURE;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.bad) begin
               ctl.op   = OP_REJECT;
               state_in = S_DONE;
            end else begin
               unique case (stat.cmd)
                  CMD_FORMAT: begin
                     fmt_in   = 1'b1;
                     state_in = S_CLEAR;
                  end
                  CMD_ALLOC: state_in = S_SCAN;
                  CMD_FREE:  state_in = S_WALK_RD;
                  CMD_PEEK:  state_in = S_PEEK_RD;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_CLEAR: begin
            ctl.op = OP_CLEAR;
            if (stat.clr_last) begin
               fmt_in   = 1'b0;
               state_in = fmt_ff ? S_DONE : S_IDLE;
            end
         end
         S_SCAN: begin
            ctl.op = OP_SCAN;
            if (stat.scan_done || stat.scan_full) begin
               state_in = S_SEAL;
            end
         end
         S_SEAL: begin
            ctl.op   = OP_SEAL;
            state_in = S_DONE;
         end
         S_WALK_RD: begin
            ctl.op   = OP_WALK_RD;
            state_in = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            ctl.op   = OP_WALK_CHK;
            state_in = stat.walk_stop ? S_DONE : S_WALK_RD;
         end
         S_PEEK_RD: begin
            ctl.op   = OP_PEEK_RD;
            state_in = S_PEEK_CHK;
         end
         S_PEEK_CHK: begin
            ctl.op   = OP_PEEK_CHK;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;     // table init sweep after reset
         fmt_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fmt_ff   <= fmt_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_DONE;

`ifndef SYNTHESIS
   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held more than one cycle");

   a_accept_decode : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_DECIDE))
      else $error("accepted request not decoded");

   a_scan_seal : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && (stat.scan_done || stat.scan_full)) |=> (state_ff == S_SEAL))
      else $error("chain not sealed after scan");

   a_no_strobe_after_init : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && stat.clr_last && !fmt_ff) |=> !rsp_valid)
      else $error("response issued for reset init sweep");
`endif

endmodule : fca_ctrl

`default_nettype wire

[rtl/core/fat_chain_allocator.sv]
// Per request: format clears every entry; read entry looks up one entry; free walks
// the chain link by link; allocate scans entries through the last block taken, or
// the whole table when the disk fills; a zero count is rejected.
// One request at a time; the next is taken in the cycle after the strobe.
// Reset: synchronous; an init sweep of the whole table follows, busy high.
// The response is a one-cycle strobe on rsp_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
// fat_chain_allocator
// Block allocation table with chained allocate, chain free, entry read
// and format requests.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_chain_allocator (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [1:0]                 req_cmd,
   input  wire logic [fca_pkg::IDX_W-1:0]  req_block_index,
   input  wire logic [fca_pkg::CNT_W-1:0]  req_block_count,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [fca_pkg::IDX_W-1:0]       rsp_result_block,
   output logic                            rsp_chain_end,
   output logic                            rsp_entry_free,
   output logic [fca_pkg::CNT_W-1:0]       rsp_blocks_changed
);
   import fca_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   fca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl),
      .stat      (stat)
   );

   fca_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .stat               (stat),
      .req_cmd            (req_cmd),
      .req_block_index    (req_block_index),
      .req_block_count    (req_block_count),
      .rsp_status         (rsp_status),
      .rsp_result_block   (rsp_result_block),
      .rsp_chain_end      (rsp_chain_end),
      .rsp_entry_free     (rsp_entry_free),
      .rsp_blocks_changed (rsp_blocks_changed)
   );

endmodule : fat_chain_allocator

`default_nettype wire
